[design/rtts_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtts_pkg
// shared types and constants of the round-trip time statistics core
// ----------------------------------------------------------------------------
package rtts_pkg;

    // request word codes
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    localparam logic [31:0] US_PER_MS       = 32'd1000;
    localparam logic [25:0] DEV_LIMIT       = 26'd65535000;
    localparam logic [63:0] SQRT_PROBE_INIT = 64'h4000_0000_0000_0000;

    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic        func;
        logic [15:0] rtt_ms;
    } req_t;

    typedef struct packed {
        logic [31:0] sample_count;
        logic [15:0] min_rtt_ms;
        logic [15:0] max_rtt_ms;
        logic [25:0] mean_us;
        logic [25:0] deviation_us;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_SQUARE,
        S_ACCUM,
        S_DIV_MEAN,
        S_MSQ_LO,
        S_MSQ_HI,
        S_MSQ_SUM,
        S_DIV_EX2,
        S_VAR,
        S_SQRT,
        S_CLAMP,
        S_FINISH
    } state_t;

endpackage : rtts_pkg
`default_nettype wire

[design/round_trip_time_statistics_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// round_trip_time_statistics_core
// running count, min, max, mean and deviation of round-trip time samples
// ----------------------------------------------------------------------------
// Each request word either adds one sample in milliseconds or clears all
// statistics; every request produces exactly one response word carrying the
// count, min, max, mean in microseconds and the deviation in microseconds.
// A sample request passes in order through scaling, squaring and accumulation,
// a 64-step restoring division for the mean, two partial products on the
// shared 32x32 multiplier for the squared mean, a second 64-step division
// for the mean of squares, one subtract, a 32-step bit-pair square root
// and a clamp. The two division passes are its longest steps. A
// clear request, and a sample with fewer than two samples held, finish early.
// One request is worked on at a time and req_ready is low meanwhile; a
// finished response sits in an output register, so a new request may be
// accepted while the previous response waits for rsp_ready.
// ----------------------------------------------------------------------------
module round_trip_time_statistics_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire rtts_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output rtts_pkg::rsp_t      rsp
);

    // sequencer state
    rtts_pkg::state_t state_reg, state_next;

    // statistics
    logic [31:0] count_reg, count_next;
    logic [15:0] min_reg, min_next;
    logic [15:0] max_reg, max_next;
    logic [63:0] sum_reg, sum_next;
    logic [63:0] sum_sq_reg, sum_sq_next;

    // working registers
    logic [15:0] sample_reg, sample_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [rtts_pkg::STEP_W-1:0] step_reg, step_next;
    logic [63:0] mean_reg, mean_next;
    logic [63:0] msq_reg, msq_next;
    logic [63:0] rad_reg, rad_next;
    logic [63:0] root_reg, root_next;
    logic [63:0] probe_reg, probe_next;
    logic [25:0] dev_reg, dev_next;

    // output register
    logic           rsp_valid_reg, rsp_valid_next;
    rtts_pkg::rsp_t rsp_reg, rsp_next;

    // shared multiplier
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_prod;

    // division step
    logic [32:0] div_shift;
    logic [32:0] div_diff;
    logic        div_ge;
    logic        div_last;

    // square root step
    logic [63:0] sqrt_trial;
    logic        sqrt_ge;

    logic        req_fire;

    assign mul_prod = mul_a * mul_b;

    // restoring division of quo_reg by count_reg, one quotient bit a cycle
    assign div_shift = {rem_reg, quo_reg[63]};
    assign div_diff  = div_shift - {1'b0, count_reg};
    assign div_ge    = (div_shift >= {1'b0, count_reg});
    assign div_last  = (step_reg == rtts_pkg::STEP_W'(rtts_pkg::DIV_STEPS - 1));

    assign sqrt_trial = root_reg + probe_reg;
    assign sqrt_ge    = (rad_reg >= sqrt_trial);

    assign req_ready = (state_reg == rtts_pkg::S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        sum_sq_next    = sum_sq_reg;
        sample_next    = sample_reg;
        prod_next      = prod_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        mean_next      = mean_reg;
        msq_next       = msq_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        probe_next     = probe_reg;
        dev_next       = dev_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        mul_a          = '0;
        mul_b          = '0;

        case (state_reg)
            rtts_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    sample_next = req.rtt_ms;
                    if (req.func == rtts_pkg::FUNC_CLEAR)
                    begin
                        count_next  = '0;
                        min_next    = '0;
                        max_next    = '0;
                        sum_next    = '0;
                        sum_sq_next = '0;
                        mean_next   = '0;
                        dev_next    = '0;
                        state_next  = rtts_pkg::S_FINISH;
                    end
                    else
                    begin
                        state_next = rtts_pkg::S_SCALE;
                    end
                end
            end

            // milliseconds to microseconds
            rtts_pkg::S_SCALE:
            begin
                mul_a      = {16'd0, sample_reg};
                mul_b      = rtts_pkg::US_PER_MS;
                prod_next  = mul_prod;
                state_next = rtts_pkg::S_SQUARE;
            end

            rtts_pkg::S_SQUARE:
            begin
                mul_a      = prod_reg[31:0];
                mul_b      = prod_reg[31:0];
                prod_next  = mul_prod;
                sum_next   = sum_reg + prod_reg;
                state_next = rtts_pkg::S_ACCUM;
            end

            rtts_pkg::S_ACCUM:
            begin
                sum_sq_next = sum_sq_reg + prod_reg;
                count_next  = count_reg + 32'd1;
                if (count_reg == '0)
                begin
                    min_next = sample_reg;
                    max_next = sample_reg;
                end
                else
                begin
                    if (sample_reg < min_reg)
                    begin
                        min_next = sample_reg;
                    end
                    if (sample_reg > max_reg)
                    begin
                        max_next = sample_reg;
                    end
                end
                // count wrapped to zero: report as empty
                if (count_next == '0)
                begin
                    mean_next  = '0;
                    dev_next   = '0;
                    state_next = rtts_pkg::S_FINISH;
                end
                else
                begin
                    quo_next   = sum_reg;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = rtts_pkg::S_DIV_MEAN;
                end
            end

            rtts_pkg::S_DIV_MEAN:
            begin
                rem_next  = div_ge ? div_diff[31:0] : div_shift[31:0];
                quo_next  = {quo_reg[62:0], div_ge};
                step_next = step_reg + 1'b1;
                if (div_last)
                begin
                    mean_next = quo_next;
                    if (count_reg[31:1] == '0)
                    begin
                        dev_next   = '0;
                        state_next = rtts_pkg::S_FINISH;
                    end
                    else
                    begin
                        state_next = rtts_pkg::S_MSQ_LO;
                    end
                end
            end

            // mean squared modulo 2^64 from two 32x32 partial products
            rtts_pkg::S_MSQ_LO:
            begin
                mul_a      = mean_reg[31:0];
                mul_b      = mean_reg[31:0];
                prod_next  = mul_prod;
                state_next = rtts_pkg::S_MSQ_HI;
            end

            rtts_pkg::S_MSQ_HI:
            begin
                msq_next   = prod_reg;
                mul_a      = mean_reg[63:32];
                mul_b      = mean_reg[31:0];
                prod_next  = mul_prod;
                state_next = rtts_pkg::S_MSQ_SUM;
            end

            rtts_pkg::S_MSQ_SUM:
            begin
                // cross term appears twice, shifted by 32
                msq_next   = msq_reg + {prod_reg[30:0], 33'd0};
                quo_next   = sum_sq_reg;
                rem_next   = '0;
                step_next  = '0;
                state_next = rtts_pkg::S_DIV_EX2;
            end

            rtts_pkg::S_DIV_EX2:
            begin
                rem_next  = div_ge ? div_diff[31:0] : div_shift[31:0];
                quo_next  = {quo_reg[62:0], div_ge};
                step_next = step_reg + 1'b1;
                if (div_last)
                begin
                    state_next = rtts_pkg::S_VAR;
                end
            end

            // variance clamped at zero, then set up the root
            rtts_pkg::S_VAR:
            begin
                rad_next   = (quo_reg > msq_reg) ? (quo_reg - msq_reg) : '0;
                root_next  = '0;
                probe_next = rtts_pkg::SQRT_PROBE_INIT;
                step_next  = '0;
                state_next = rtts_pkg::S_SQRT;
            end

            rtts_pkg::S_SQRT:
            begin
                if (sqrt_ge)
                begin
                    rad_next  = rad_reg - sqrt_trial;
                    root_next = (root_reg >> 1) + probe_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                probe_next = probe_reg >> 2;
                step_next  = step_reg + 1'b1;
                if (step_reg == rtts_pkg::STEP_W'(rtts_pkg::SQRT_STEPS - 1))
                begin
                    state_next = rtts_pkg::S_CLAMP;
                end
            end

            rtts_pkg::S_CLAMP:
            begin
                dev_next   = (root_reg > {38'd0, rtts_pkg::DEV_LIMIT}) ?
                             rtts_pkg::DEV_LIMIT : root_reg[25:0];
                state_next = rtts_pkg::S_FINISH;
            end

            // hand the word over once the output register is free
            rtts_pkg::S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.sample_count = count_reg;
                    rsp_next.min_rtt_ms   = min_reg;
                    rsp_next.max_rtt_ms   = max_reg;
                    rsp_next.mean_us      = mean_reg[25:0];
                    rsp_next.deviation_us = dev_reg;
                    rsp_valid_next        = 1'b1;
                    state_next            = rtts_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = rtts_pkg::S_IDLE;
            end
        endcase
    end

    // control state and statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtts_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            sum_reg       <= '0;
            sum_sq_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            count_reg     <= count_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            sum_sq_reg    <= sum_sq_next;
        end
    end

    // datapath working registers
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        prod_reg   <= prod_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        mean_reg   <= mean_next;
        msq_reg    <= msq_next;
        rad_reg    <= rad_next;
        root_reg   <= root_next;
        probe_reg  <= probe_next;
        dev_reg    <= dev_next;
        rsp_reg    <= rsp_next;
    end

    // a response word only appears out of the finish step
    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == rtts_pkg::S_FINISH))
        else $error("response raised outside finish step");

    // min never exceeds max while samples are held
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (min_reg <= max_reg))
        else $error("min above max");

    // a clear word empties the statistics
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.func == rtts_pkg::FUNC_CLEAR) |=>
        (count_reg == '0 && sum_reg == '0 && sum_sq_reg == '0))
        else $error("clear did not empty statistics");

    // deviation is zero below two samples
    a_dev_small_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.sample_count < 32'd2) |->
        (rsp_reg.deviation_us == '0))
        else $error("deviation nonzero below two samples");

endmodule : round_trip_time_statistics_core
`default_nettype wire
